// ===== design/rtle_pkg.sv =====
// Shared types and constants for the route table lookup engine.
package rtle_pkg;

    localparam logic [3:0] FN_CLEAR       = 4'd0;
    localparam logic [3:0] FN_LOAD        = 4'd1;
    localparam logic [3:0] FN_UPDATE      = 4'd2;
    localparam logic [3:0] FN_LINK        = 4'd3;
    localparam logic [3:0] FN_READ        = 4'd4;
    localparam logic [3:0] FN_FIND_ID     = 4'd5;
    localparam logic [3:0] FN_FIND_SERIAL = 4'd6;
    localparam logic [3:0] FN_COMPARE     = 4'd7;
    localparam logic [3:0] FN_ROUTE       = 4'd8;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;
    localparam logic [7:0] LINK_ON     = 8'h01;
    localparam logic [7:0] NO_MATCH    = 8'hFF;
    localparam logic [7:0] DIRECT_HOP  = 8'hFF;

    localparam logic [1:0] ROUTE_VALID = 2'd1;
    localparam logic [1:0] ROUTE_KNOWN = 2'd2;
    localparam logic [1:0] ROUTE_NONE  = 2'd3;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_LOAD,
        OP_UPDATE,
        OP_LINK,
        OP_READ,
        OP_FIND_ID,
        OP_FIND_SERIAL,
        OP_COMPARE,
        OP_ROUTE
    } t_op;

    typedef struct packed {
        logic [3:0]  func;
        logic [5:0]  entry_index;
        logic [47:0] serial;
        logic [7:0]  net_id;
        logic [7:0]  relay_depth;
        logic [7:0]  parent;
        logic [7:0]  backup_parent;
        logic [7:0]  link_flag;
        logic [1:0]  prior_status;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  found_index;
        logic [47:0] entry_serial;
        logic [7:0]  entry_net_id;
        logic [7:0]  entry_relay;
        logic [7:0]  entry_parent;
        logic [7:0]  entry_backup;
        logic [7:0]  entry_link;
        logic [1:0]  match_status;
        logic [1:0]  route_result;
    } t_out_item;

    typedef struct packed {
        logic [47:0] serial;
        logic [7:0]  net_id;
        logic [7:0]  relay;
        logic [7:0]  parent;
        logic [7:0]  backup;
        logic [7:0]  link;
    } t_entry;

    localparam int     ENTRY_W      = $bits(t_entry);
    localparam t_entry ERASED_ENTRY = '1;

    // Decoded command handed from the front end to the back end.
    typedef struct packed {
        t_op         op;
        logic        in_table;
        logic [5:0]  idx;
        logic [47:0] serial;
        logic [7:0]  net_id;
        logic [7:0]  relay;
        logic [7:0]  parent;
        logic [7:0]  backup;
        logic [7:0]  link;
        logic [1:0]  status;
    } t_cmd;

endpackage

// ===== design/rtle_in_if.sv =====
// Request channel carrying one lookup engine command word.
interface rtle_in_if;
    logic               valid;
    logic               ready;
    rtle_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/rtle_out_if.sv =====
// Response channel carrying one lookup engine result word.
interface rtle_out_if;
    logic                valid;
    logic                ready;
    rtle_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/rtle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rtle_ram #(
    parameter int   WIDTH = 8,
    parameter int   DEPTH = 16,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/rtle_front.sv =====
// Front end: accepts request words, decodes them and queues the commands.
module rtle_front #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rtle_in_if.sink          i_req,
    output rtle_pkg::t_cmd   o_cmd,
    output logic             o_cmd_valid,
    input  logic             i_cmd_pop
);

    localparam int QD = 2;

    rtle_pkg::t_cmd r_q [QD];
    rtle_pkg::t_cmd n_cmd;
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    logic           w_push;
    logic           w_pop;

    assign i_req.ready = (r_cnt != 2'(QD));
    assign w_push      = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_cmd          = '0;
        n_cmd.in_table = ({2'b00, i_req.data.entry_index} < 8'(TABLE_ENTRIES));
        n_cmd.idx      = i_req.data.entry_index;
        n_cmd.serial   = i_req.data.serial;
        n_cmd.net_id   = i_req.data.net_id;
        n_cmd.relay    = i_req.data.relay_depth;
        n_cmd.parent   = i_req.data.parent;
        n_cmd.backup   = i_req.data.backup_parent;
        n_cmd.link     = i_req.data.link_flag;
        n_cmd.status   = i_req.data.prior_status;
        case (i_req.data.func)
            rtle_pkg::FN_CLEAR:       n_cmd.op = rtle_pkg::OP_CLEAR;
            rtle_pkg::FN_LOAD:        n_cmd.op = rtle_pkg::OP_LOAD;
            rtle_pkg::FN_UPDATE:      n_cmd.op = rtle_pkg::OP_UPDATE;
            rtle_pkg::FN_LINK:        n_cmd.op = rtle_pkg::OP_LINK;
            rtle_pkg::FN_READ:        n_cmd.op = rtle_pkg::OP_READ;
            rtle_pkg::FN_FIND_ID:     n_cmd.op = rtle_pkg::OP_FIND_ID;
            rtle_pkg::FN_FIND_SERIAL: n_cmd.op = rtle_pkg::OP_FIND_SERIAL;
            rtle_pkg::FN_COMPARE:     n_cmd.op = rtle_pkg::OP_COMPARE;
            rtle_pkg::FN_ROUTE:       n_cmd.op = rtle_pkg::OP_ROUTE;
            default:                  n_cmd.op = rtle_pkg::OP_NOP;
        endcase
    end

    assign n_cnt = 2'(r_cnt + {1'b0, w_push} - {1'b0, w_pop});

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QD))
        else $error("command queue count out of range");

    a_pop_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> r_cnt != 2'(QD))
        else $error("queue still full after a pop");
`endif

endmodule

// ===== design/rtle_back.sv =====
// Back end: executes queued commands against the route table and holds the result.
module rtle_back #(
    parameter int   TABLE_ENTRIES = 64,
    localparam int  AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
    localparam int  LW = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rtle_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    input  logic [6:0]     i_entries_in_use,
    rtle_out_if.source     o_rsp
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_WAIT = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    rtle_pkg::t_cmd          r_cmd;
    logic [LW-1:0]           r_len;
    logic [LW-1:0]           w_len;
    logic [LW-1:0]           r_issue;
    logic                    r_chk_v;
    logic [AW-1:0]           r_chk_idx;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic                    r_rd_valid;
    rtle_pkg::t_entry        r_rd_entry;
    logic [rtle_pkg::ENTRY_W-1:0] w_rdata;
    rtle_pkg::t_entry        w_entry;
    rtle_pkg::t_entry        w_wdata;
    logic                    w_we;
    logic [AW-1:0]           w_cmd_addr;
    logic [AW-1:0]           w_raddr;
    logic                    w_issue;
    logic                    w_scan_end;
    logic                    w_serial_eq;
    logic                    w_id_eq;
    logic                    w_linked;
    logic                    w_find_eq;
    logic                    r_found;
    logic [AW-1:0]           r_found_idx;
    logic                    r_hit_serial;
    logic                    r_hit_id;
    logic                    r_known;
    logic                    r_parent_linked;
    rtle_pkg::t_out_item     w_res;
    rtle_pkg::t_out_item     r_out;
    logic                    r_out_valid;
    logic                    w_load_out;
    logic [7:0]              w_cfg8;

    // Scan length is the configured count, capped at the table size.
    assign w_cfg8 = {1'b0, i_entries_in_use};
    assign w_len  = (w_cfg8 > 8'(TABLE_ENTRIES)) ? LW'(TABLE_ENTRIES) : LW'(w_cfg8);

    assign w_cmd_addr = AW'(r_cmd.idx);
    assign w_issue    = (r_state == S_SCAN) && (r_issue != r_len);
    assign w_scan_end = (r_issue == r_len) && !r_chk_v;
    assign w_raddr    = (r_state == S_SCAN) ? r_issue[AW-1:0] : w_cmd_addr;
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    // Entries never written since reset or clear read as erased.
    assign w_entry = r_rd_valid ? rtle_pkg::t_entry'(w_rdata) : rtle_pkg::ERASED_ENTRY;

    assign w_serial_eq = (w_entry.serial == r_cmd.serial);
    assign w_id_eq     = (w_entry.net_id == r_cmd.net_id);
    assign w_linked    = (w_entry.link == rtle_pkg::LINK_ON);
    assign w_find_eq   = (r_cmd.op == rtle_pkg::OP_FIND_ID) ? w_id_eq : w_serial_eq;

    always_comb begin
        w_wdata = w_entry;
        case (r_cmd.op)
            rtle_pkg::OP_LOAD: begin
                w_wdata.serial = r_cmd.serial;
                w_wdata.net_id = r_cmd.net_id;
            end
            rtle_pkg::OP_UPDATE: begin
                w_wdata.net_id = r_cmd.net_id;
                w_wdata.relay  = r_cmd.relay;
                w_wdata.parent = r_cmd.parent;
                w_wdata.backup = r_cmd.backup;
                w_wdata.link   = r_cmd.link;
            end
            rtle_pkg::OP_LINK: begin
                w_wdata.link = r_cmd.link;
            end
            default: begin
                w_wdata = w_entry;
            end
        endcase
    end

    assign w_we = (r_state == S_WAIT) && (r_cmd.op != rtle_pkg::OP_READ);

    rtle_ram #(
        .WIDTH (rtle_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_cmd_addr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd.op)
                    rtle_pkg::OP_LOAD, rtle_pkg::OP_UPDATE,
                    rtle_pkg::OP_LINK, rtle_pkg::OP_READ: begin
                        n_state = r_cmd.in_table ? S_WAIT : S_DONE;
                    end
                    rtle_pkg::OP_FIND_ID, rtle_pkg::OP_FIND_SERIAL,
                    rtle_pkg::OP_COMPARE, rtle_pkg::OP_ROUTE: begin
                        n_state = S_SCAN;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_WAIT: n_state = S_DONE;
            S_SCAN: begin
                if (w_scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_res             = '0;
        w_res.found_index = rtle_pkg::NO_MATCH;
        case (r_cmd.op)
            rtle_pkg::OP_READ: begin
                w_res.entry_serial = r_rd_entry.serial;
                w_res.entry_net_id = r_rd_entry.net_id;
                w_res.entry_relay  = r_rd_entry.relay;
                w_res.entry_parent = r_rd_entry.parent;
                w_res.entry_backup = r_rd_entry.backup;
                w_res.entry_link   = r_rd_entry.link;
            end
            rtle_pkg::OP_FIND_ID, rtle_pkg::OP_FIND_SERIAL: begin
                if (r_found) begin
                    w_res.found_index = 8'(r_found_idx);
                end
            end
            rtle_pkg::OP_COMPARE: begin
                w_res.match_status = {r_hit_id, r_hit_serial};
            end
            rtle_pkg::OP_ROUTE: begin
                if (r_known) begin
                    w_res.route_result = rtle_pkg::ROUTE_KNOWN;
                end else if (r_cmd.parent == rtle_pkg::DIRECT_HOP || r_parent_linked) begin
                    w_res.route_result = rtle_pkg::ROUTE_VALID;
                end else begin
                    w_res.route_result = rtle_pkg::ROUTE_NONE;
                end
            end
            default: begin
                w_res.found_index = rtle_pkg::NO_MATCH;
            end
        endcase
    end

    // Datapath registers; each is initialized by the state that starts using it.
    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_valid[w_raddr];
        r_chk_idx  <= r_issue[AW-1:0];
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
            r_len <= w_len;
        end
        if (r_state == S_WAIT) begin
            r_rd_entry <= w_entry;
        end
        if (r_state == S_EXEC) begin
            r_rd_entry      <= rtle_pkg::ERASED_ENTRY;
            r_found         <= 1'b0;
            r_found_idx     <= '0;
            r_hit_serial    <= 1'b0;
            r_hit_id        <= 1'b0;
            r_known         <= 1'b0;
            r_parent_linked <= 1'b0;
        end else if (r_chk_v) begin
            if (!r_found && w_find_eq) begin
                r_found     <= 1'b1;
                r_found_idx <= r_chk_idx;
            end
            if (w_serial_eq) begin
                r_hit_serial <= 1'b1;
            end
            if (w_id_eq) begin
                r_hit_id <= 1'b1;
            end
            if (r_cmd.status[0] && w_id_eq && w_linked && w_entry.parent == r_cmd.parent) begin
                r_known <= 1'b1;
            end
            if (w_linked && w_entry.net_id == r_cmd.parent) begin
                r_parent_linked <= 1'b1;
            end
        end
        if (w_load_out) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= '0;
            r_chk_v     <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_issue <= '0;
                r_chk_v <= 1'b0;
            end else begin
                r_chk_v <= w_issue;
                if (w_issue) begin
                    r_issue <= LW'(r_issue + 1'b1);
                end
            end
            if (r_state == S_EXEC && r_cmd.op == rtle_pkg::OP_CLEAR) begin
                r_valid <= '0;
            end else if (w_we) begin
                r_valid[w_cmd_addr] <= 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

`ifndef NO_ASSERTIONS
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_issue <= r_len)
        else $error("scan ran past the entry count");

    a_wait_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WAIT |-> r_cmd.in_table && $past(r_state) == S_EXEC)
        else $error("table access outside the table");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !o_rsp.ready) |=> r_state == S_DONE)
        else $error("result dropped while output word was pending");
`endif

endmodule

// ===== design/route_table_lookup_engine.sv =====
// Each command runs alone in the back end: writes and reads in the table pass EXEC, WAIT and DONE;
// clear, other functions and indexes beyond the table pass EXEC and DONE; searches scan n entries,
// n = min(entries_in_use, TABLE_ENTRIES), through the single table read port, one entry per cycle;
// a two-deep queue decouples the input, so new words are taken while one is in progress.
// Reset: synchronous; entries read as erased (0xFF) via valid flags, entries_in_use is 0.
module route_table_lookup_engine #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rtle_in_if.sink    i_req,
    rtle_out_if.source o_rsp,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata
);

    logic [6:0]     r_entries_in_use;
    rtle_pkg::t_cmd w_cmd;
    logic           w_cmd_valid;
    logic           w_cmd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= 7'd0;
        end else if (i_cfg_we) begin
            r_entries_in_use <= i_cfg_wdata;
        end
    end

    rtle_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    rtle_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cmd_valid      (w_cmd_valid),
        .o_cmd_pop        (w_cmd_pop),
        .i_entries_in_use (r_entries_in_use),
        .o_rsp            (o_rsp)
    );

endmodule

// ===== test/route_table_checker.sv =====
// Checker that mirrors the route table and compares every result word of the lookup engine.
module route_table_checker #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic                i_req_ready,
    input  rtle_pkg::t_in_item  i_req_data,
    input  logic                i_rsp_valid,
    input  logic                i_rsp_ready,
    input  rtle_pkg::t_out_item i_rsp_data,
    input  logic                i_cfg_we,
    input  logic [6:0]          i_cfg_wdata,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHOWN_FAULTS = 10;

    rtle_pkg::t_entry    mirror_table [TABLE_ENTRIES];
    logic [6:0]          scan_setting;
    rtle_pkg::t_out_item awaited_results [$];
    int                  fault_total = 0;

    function automatic int scan_count();
        return (int'(scan_setting) > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(scan_setting);
    endfunction

    function automatic logic [1:0] classify_route(logic [1:0] status, logic [7:0] id,
                                                  logic [7:0] hop);
        int n = scan_count();
        // A route is only recognized as known when the earlier compare saw the serial.
        if (status[0]) begin
            for (int i = 0; i < n; i++) begin
                if (mirror_table[i].net_id == id && mirror_table[i].parent == hop &&
                    mirror_table[i].link == rtle_pkg::LINK_ON) begin
                    return rtle_pkg::ROUTE_KNOWN;
                end
            end
        end
        if (hop == rtle_pkg::DIRECT_HOP) begin
            return rtle_pkg::ROUTE_VALID;
        end
        for (int i = 0; i < n; i++) begin
            if (mirror_table[i].net_id == hop && mirror_table[i].link == rtle_pkg::LINK_ON) begin
                return rtle_pkg::ROUTE_VALID;
            end
        end
        return rtle_pkg::ROUTE_NONE;
    endfunction

    // Applies one command word to the mirror table and returns the result word it must give.
    function automatic rtle_pkg::t_out_item apply_route_word(rtle_pkg::t_in_item w);
        rtle_pkg::t_out_item r;
        rtle_pkg::t_entry    e;
        int                  n;
        logic                hit_in;
        r             = '0;
        r.found_index = rtle_pkg::NO_MATCH;
        n             = scan_count();
        hit_in        = int'(w.entry_index) < TABLE_ENTRIES;
        case (w.func)
            rtle_pkg::FN_CLEAR: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    mirror_table[i] = rtle_pkg::ERASED_ENTRY;
                end
            end
            rtle_pkg::FN_LOAD: begin
                if (hit_in) begin
                    mirror_table[w.entry_index].serial = w.serial;
                    mirror_table[w.entry_index].net_id = w.net_id;
                end
            end
            rtle_pkg::FN_UPDATE: begin
                if (hit_in) begin
                    mirror_table[w.entry_index].net_id = w.net_id;
                    mirror_table[w.entry_index].relay  = w.relay_depth;
                    mirror_table[w.entry_index].parent = w.parent;
                    mirror_table[w.entry_index].backup = w.backup_parent;
                    mirror_table[w.entry_index].link   = w.link_flag;
                end
            end
            rtle_pkg::FN_LINK: begin
                if (hit_in) begin
                    mirror_table[w.entry_index].link = w.link_flag;
                end
            end
            rtle_pkg::FN_READ: begin
                e = rtle_pkg::ERASED_ENTRY;
                if (hit_in) begin
                    e = mirror_table[w.entry_index];
                end
                r.entry_serial = e.serial;
                r.entry_net_id = e.net_id;
                r.entry_relay  = e.relay;
                r.entry_parent = e.parent;
                r.entry_backup = e.backup;
                r.entry_link   = e.link;
            end
            rtle_pkg::FN_FIND_ID: begin
                // Scanning downward leaves the lowest matching index in place.
                for (int i = n - 1; i >= 0; i--) begin
                    if (mirror_table[i].net_id == w.net_id) begin
                        r.found_index = 8'(i);
                    end
                end
            end
            rtle_pkg::FN_FIND_SERIAL: begin
                for (int i = n - 1; i >= 0; i--) begin
                    if (mirror_table[i].serial == w.serial) begin
                        r.found_index = 8'(i);
                    end
                end
            end
            rtle_pkg::FN_COMPARE: begin
                for (int i = 0; i < n; i++) begin
                    if (mirror_table[i].serial == w.serial) begin
                        r.match_status[0] = 1'b1;
                    end
                    if (mirror_table[i].net_id == w.net_id) begin
                        r.match_status[1] = 1'b1;
                    end
                end
            end
            rtle_pkg::FN_ROUTE: begin
                r.route_result = classify_route(w.prior_status, w.net_id, w.parent);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic check_field(string label, logic [47:0] want, logic [47:0] got);
        if (got !== want) begin
            fault_total++;
            if (fault_total <= SHOWN_FAULTS) begin
                $display("%0t ns: %s mismatch, expected %h, got %h", $time, label, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        rtle_pkg::t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                mirror_table[i] = rtle_pkg::ERASED_ENTRY;
            end
            scan_setting = '0;
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                scan_setting = i_cfg_wdata;
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (awaited_results.size() == 0) begin
                    fault_total++;
                    if (fault_total <= SHOWN_FAULTS) begin
                        $display("%0t ns: result word %h arrived with no command waiting",
                                 $time, i_rsp_data);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    check_field("found_index", want.found_index, i_rsp_data.found_index);
                    check_field("entry_serial", want.entry_serial, i_rsp_data.entry_serial);
                    check_field("entry_net_id", want.entry_net_id, i_rsp_data.entry_net_id);
                    check_field("entry_relay", want.entry_relay, i_rsp_data.entry_relay);
                    check_field("entry_parent", want.entry_parent, i_rsp_data.entry_parent);
                    check_field("entry_backup", want.entry_backup, i_rsp_data.entry_backup);
                    check_field("entry_link", want.entry_link, i_rsp_data.entry_link);
                    check_field("match_status", want.match_status, i_rsp_data.match_status);
                    check_field("route_result", want.route_result, i_rsp_data.route_result);
                end
            end
            if (i_req_valid && i_req_ready) begin
                awaited_results.push_back(apply_route_word(i_req_data));
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= fault_total;
    end

endmodule

// ===== test/tb_route_table_lookup_engine.sv =====
// Stimulus and verdict for the route table lookup engine, checked by route_table_checker.
module tb_route_table_lookup_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TABLE_ENTRIES = 64;
    localparam logic [47:0] SERIAL_ONES   = '1;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;
    int          fail_count;
    int          pending;
    bit          sender_idles;
    bit          sink_stalls;
    int          stall_left = 0;
    logic [7:0]  id_pool [8];
    logic [47:0] serial_pool [6];

    rtle_in_if  req_bus ();
    rtle_out_if rsp_bus ();

    route_table_lookup_engine #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    route_table_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_bus.valid),
        .i_req_ready (req_bus.ready),
        .i_req_data  (req_bus.data),
        .i_rsp_valid (rsp_bus.valid),
        .i_rsp_ready (rsp_bus.ready),
        .i_rsp_data  (rsp_bus.data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // The result side randomly holds ready low in bursts while sink_stalls is set.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            rsp_bus.ready <= 1'b0;
        end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
            stall_left    <= $urandom_range(0, 5);
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= 1'b1;
        end
    end

    function automatic rtle_pkg::t_in_item route_cmd(logic [3:0] fn, logic [5:0] idx,
                                                     logic [47:0] serial, logic [7:0] id,
                                                     logic [7:0] relay, logic [7:0] hop,
                                                     logic [7:0] backup, logic [7:0] link,
                                                     logic [1:0] status);
        rtle_pkg::t_in_item w;
        w.func          = fn;
        w.entry_index   = idx;
        w.serial        = serial;
        w.net_id        = id;
        w.relay_depth   = relay;
        w.parent        = hop;
        w.backup_parent = backup;
        w.link_flag     = link;
        w.prior_status  = status;
        return w;
    endfunction

    // Leaves valid high after acceptance so that back-to-back words go out without a gap.
    task automatic send_word(rtle_pkg::t_in_item w);
        req_bus.valid <= 1'b1;
        req_bus.data  <= w;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
    endtask

    task automatic maybe_gap();
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // The pending count is registered, so valid goes low and the task waits on the clock before reading it.
    task automatic drain_results();
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_scan(int setting);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= 7'(setting);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int setting, int count, int pause_at);
        rtle_pkg::t_in_item w;
        int                 pick;
        int                 span;
        set_scan(setting);
        span = (setting > TABLE_ENTRIES - 1) ? TABLE_ENTRIES - 1 : setting;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            w.func = (pick < 2)  ? rtle_pkg::FN_CLEAR :
                     (pick < 12) ? rtle_pkg::FN_LOAD :
                     (pick < 27) ? rtle_pkg::FN_UPDATE :
                     (pick < 34) ? rtle_pkg::FN_LINK :
                     (pick < 46) ? rtle_pkg::FN_READ :
                     (pick < 58) ? rtle_pkg::FN_FIND_ID :
                     (pick < 68) ? rtle_pkg::FN_FIND_SERIAL :
                     (pick < 78) ? rtle_pkg::FN_COMPARE :
                     (pick < 96) ? rtle_pkg::FN_ROUTE :
                                   rtle_pkg::FN_ROUTE + 4'($urandom_range(1, 7));
            // Most writes land inside the scanned range so that searches find them.
            w.entry_index = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, span)) :
                                                          6'($urandom);
            w.serial = ($urandom_range(0, 9) < 7) ? serial_pool[$urandom_range(0, 5)] :
                                                    {16'($urandom), 32'($urandom)};
            w.net_id = ($urandom_range(0, 3) != 0) ? id_pool[$urandom_range(0, 7)] :
                                                     8'($urandom);
            pick = $urandom_range(0, 19);
            w.parent = (pick < 9)  ? id_pool[$urandom_range(0, 7)] :
                       (pick < 13) ? rtle_pkg::DIRECT_HOP : 8'($urandom);
            pick = $urandom_range(0, 19);
            w.link_flag = (pick < 9)  ? rtle_pkg::LINK_ON :
                          (pick < 13) ? 8'h00 :
                          (pick < 16) ? rtle_pkg::ERASED_BYTE : 8'($urandom);
            w.relay_depth   = 8'($urandom);
            w.backup_parent = 8'($urandom);
            w.prior_status  = 2'($urandom);
            maybe_gap();
            if (k == pause_at) begin
                drain_results();
            end
            send_word(w);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        req_bus.valid = 1'b0;
        req_bus.data  = '0;
        sender_idles  = 1'b1;
        sink_stalls   = 1'b1;
        id_pool[0]     = 8'h00;
        id_pool[1]     = rtle_pkg::ERASED_BYTE;
        serial_pool[0] = '0;
        serial_pool[1] = SERIAL_ONES;
        for (int i = 2; i < 8; i++) begin
            id_pool[i] = 8'($urandom);
        end
        for (int i = 2; i < 6; i++) begin
            serial_pool[i] = {16'($urandom), 32'($urandom)};
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Nothing is scanned right after reset.
        send_word(route_cmd(rtle_pkg::FN_READ, 6'd0, '0, '0, '0, '0, '0, '0, 2'd0));
        send_word(route_cmd(rtle_pkg::FN_FIND_ID, 6'd0, '0, rtle_pkg::ERASED_BYTE, '0, '0, '0,
                            '0, 2'd0));
        send_word(route_cmd(rtle_pkg::FN_ROUTE, 6'd0, '0, 8'h00, '0, 8'h05, '0, '0, 2'd1));
        set_scan(8);
        // Erased entries match an all-ones serial and net id.
        send_word(route_cmd(rtle_pkg::FN_COMPARE, 6'd0, SERIAL_ONES, rtle_pkg::ERASED_BYTE, '0,
                            '0, '0, '0, 2'd0));
        send_word(route_cmd(rtle_pkg::FN_LOAD, 6'd0, '0, 8'h00, '0, '0, '0, '0, 2'd0));
        send_word(route_cmd(rtle_pkg::FN_LOAD, 6'd63, SERIAL_ONES, 8'h12, '1, '1, '1, '1,
                            2'd3));
        send_word(route_cmd(rtle_pkg::FN_UPDATE, 6'd1, '0, 8'h21, 8'h00, rtle_pkg::DIRECT_HOP,
                            8'h00, rtle_pkg::LINK_ON, 2'd0));
        send_word(route_cmd(rtle_pkg::FN_UPDATE, 6'd2, '0, 8'h33, 8'hFF, 8'h21, 8'hFF,
                            rtle_pkg::LINK_ON, 2'd0));
        send_word(route_cmd(rtle_pkg::FN_LINK, 6'd2, '0, '0, '0, '0, '0, 8'h00, 2'd0));
        send_word(route_cmd(rtle_pkg::FN_ROUTE, 6'd0, '0, 8'h33, '0, 8'h21, '0, '0, 2'd1));
        send_word(route_cmd(rtle_pkg::FN_LINK, 6'd2, '0, '0, '0, '0, '0, rtle_pkg::LINK_ON,
                            2'd0));
        send_word(route_cmd(rtle_pkg::FN_READ, 6'd0, '0, '0, '0, '0, '0, '0, 2'd0));
        send_word(route_cmd(rtle_pkg::FN_READ, 6'd63, '0, '0, '0, '0, '0, '0, 2'd0));
        send_word(route_cmd(rtle_pkg::FN_READ, 6'd2, '0, '0, '0, '0, '0, '0, 2'd0));
        send_word(route_cmd(rtle_pkg::FN_FIND_ID, 6'd0, '0, 8'h21, '0, '0, '0, '0, 2'd0));
        send_word(route_cmd(rtle_pkg::FN_FIND_ID, 6'd0, '0, 8'h12, '0, '0, '0, '0, 2'd0));
        send_word(route_cmd(rtle_pkg::FN_FIND_SERIAL, 6'd0, '0, '0, '0, '0, '0, '0, 2'd0));
        send_word(route_cmd(rtle_pkg::FN_FIND_SERIAL, 6'd0, SERIAL_ONES, '0, '0, '0, '0, '0,
                            2'd0));
        send_word(route_cmd(rtle_pkg::FN_COMPARE, 6'd0, '0, 8'h33, '0, '0, '0, '0, 2'd0));
        send_word(route_cmd(rtle_pkg::FN_ROUTE, 6'd0, '0, 8'h33, '0, 8'h21, '0, '0, 2'd3));
        send_word(route_cmd(rtle_pkg::FN_ROUTE, 6'd0, '0, 8'h33, '0, 8'h21, '0, '0, 2'd2));
        send_word(route_cmd(rtle_pkg::FN_ROUTE, 6'd0, '0, 8'h44, '0, rtle_pkg::DIRECT_HOP, '0,
                            '0, 2'd0));
        send_word(route_cmd(rtle_pkg::FN_ROUTE + 4'd1, 6'd5, SERIAL_ONES, '1, '1, '1, '1, '1,
                            2'd3));
        send_word(route_cmd('1, 6'd5, SERIAL_ONES, '1, '1, '1, '1, '1, 2'd3));
        send_word(route_cmd(rtle_pkg::FN_CLEAR, 6'd0, '0, '0, '0, '0, '0, '0, 2'd0));
        send_word(route_cmd(rtle_pkg::FN_READ, 6'd2, '0, '0, '0, '0, '0, '0, 2'd0));

        run_phase(64, 150, -1);
        run_phase(1, 100, -1);
        run_phase(127, 150, 75);
        run_phase(23, 120, -1);
        run_phase(0, 60, -1);
        run_phase(40, 120, -1);
        sender_idles = 1'b0;
        sink_stalls <= 1'b0;
        run_phase(64, 150, -1);

        drain_results();
        repeat (80) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_route_table_lookup_engine passed");
        end else begin
            $display("tb_route_table_lookup_engine failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb_route_table_lookup_engine failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rtle_pkg.sv
design/rtle_in_if.sv
design/rtle_out_if.sv
design/rtle_ram.sv
design/rtle_front.sv
design/rtle_back.sv
design/route_table_lookup_engine.sv
test/route_table_checker.sv
test/tb_route_table_lookup_engine.sv
